// ----- rtl/core/cset_pkg.sv -----
// ----------------------------------------------------------------------------
// cset_pkg
// Field widths, event modes and status codes of the call stack exclusive timer.
// ----------------------------------------------------------------------------
package cset_pkg;

	localparam int MODE_W   = 2;
	localparam int ID_W     = 8;
	localparam int TS_W     = 32;
	localparam int TOT_W    = 33;
	localparam int STATUS_W = 2;

	localparam logic [MODE_W-1:0] MODE_START = 2'd0;
	localparam logic [MODE_W-1:0] MODE_END   = 2'd1;
	localparam logic [MODE_W-1:0] MODE_READ  = 2'd2;

	localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
	localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 2'd1;
	localparam logic [STATUS_W-1:0] ST_UNDERFLOW = 2'd2;

endpackage

// ----- rtl/core/cset_ram.sv -----
// ----------------------------------------------------------------------------
// cset_ram
// Simple dual-port synchronous memory with one write port and one registered
// read port.
// ----------------------------------------------------------------------------
module cset_ram #(
	parameter int W     = 8,
	parameter int DEPTH = 4,
	parameter int AW    = 2
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [W-1:0]  wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [W-1:0]  rdata
);

	logic [W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- rtl/core/call_stack_exclusive_timer.sv -----
// ----------------------------------------------------------------------------
// call_stack_exclusive_timer
// Exclusive-time profiler for nested calls, built around a totals memory
// and a call stack memory.
// ----------------------------------------------------------------------------
// An event is transferred at a rising edge where start is high and busy is
// low. mode selects a start event (push func_id), an end event (credit and
// pop the running function) or a read of one function's total.
// Every event gives exactly one result: done is high for one cycle while
// status, credited_valid, credited_id and credited_total hold it. The
// receiver takes the result in that cycle and cannot hold it off.
// An event has an accept cycle and an execute cycle: the accept cycle reads
// the totals and stack memories; the execute cycle adds the elapsed time,
// writes the totals memory back on a credit and the stack memory on a push
// and registers the result. busy is high in the execute cycle, so no event is
// taken then. The result shows in the cycle busy falls, when the next may be taken.
// The running function and its resume time sit in registers; the stack
// memory holds the ids of the callers below it.
// After reset busy stays high while the totals memory is swept to zero, one
// entry a cycle. Stack contents need no clearing.
// ----------------------------------------------------------------------------
module call_stack_exclusive_timer #(
	parameter int MAX_FUNCS   = 256,
	parameter int STACK_DEPTH = 256
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [cset_pkg::MODE_W-1:0]   mode,
	input  logic [cset_pkg::ID_W-1:0]     func_id,
	input  logic [cset_pkg::TS_W-1:0]     timestamp,
	output logic                          busy,
	output logic                          done,
	output logic [cset_pkg::STATUS_W-1:0] status,
	output logic                          credited_valid,
	output logic [cset_pkg::ID_W-1:0]     credited_id,
	output logic [cset_pkg::TOT_W-1:0]    credited_total
);

	localparam int FID_W  = $clog2(MAX_FUNCS);
	localparam int LVL_W  = $clog2(STACK_DEPTH + 1);
	localparam int SP_W   = $clog2(STACK_DEPTH);
	localparam int SENT_W = FID_W;
	localparam int RED_W  = 25;

	localparam logic [1:0] S_CLEAR = 2'd0;
	localparam logic [1:0] S_IDLE  = 2'd1;
	localparam logic [1:0] S_EXEC  = 2'd2;

	localparam logic [2:0] OP_NONE       = 3'd0;
	localparam logic [2:0] OP_PUSH_FIRST = 3'd1;
	localparam logic [2:0] OP_PUSH       = 3'd2;
	localparam logic [2:0] OP_POP        = 3'd3;
	localparam logic [2:0] OP_READ       = 3'd4;

	// Reduce an id modulo MAX_FUNCS by restoring subtraction of shifted
	// multiples; ids are only eight bits wide.
	function automatic logic [FID_W-1:0] fold_id(input logic [cset_pkg::ID_W-1:0] id);
		logic [RED_W-1:0] r;
		logic [RED_W-1:0] m;
		r = RED_W'(id);
		for (int k = cset_pkg::ID_W - 1; k >= 0; k--) begin
			m = RED_W'(MAX_FUNCS) << k;
			if (r >= m) begin
				r = r - m;
			end
		end
		return r[FID_W-1:0];
	endfunction

	logic [1:0]                       state_q;
	logic [FID_W-1:0]                 clr_q;
	logic [LVL_W-1:0]                 level_q;
	logic [FID_W-1:0]                 top_id_q;
	logic [cset_pkg::TS_W-1:0]        top_time_q;
	logic [2:0]                       op_s1;
	logic [cset_pkg::STATUS_W-1:0]    stat_s1;
	logic [FID_W-1:0]                 fid_s1;
	logic [cset_pkg::TS_W-1:0]        ts_s1;
	logic [cset_pkg::TOT_W-1:0]       elapsed_s1;

	logic                             done_q;
	logic [cset_pkg::STATUS_W-1:0]    status_q;
	logic                             valid_q;
	logic [cset_pkg::ID_W-1:0]        id_q;
	logic [cset_pkg::TOT_W-1:0]       total_q;

	logic                             accept;
	logic [FID_W-1:0]                 fid_fold;
	logic [cset_pkg::TOT_W-1:0]       now_d;
	logic [cset_pkg::TOT_W-1:0]       elapsed_d;
	logic [2:0]                       op_d;
	logic [cset_pkg::STATUS_W-1:0]    stat_d;

	logic                             tot_we;
	logic [FID_W-1:0]                 tot_waddr;
	logic [cset_pkg::TOT_W-1:0]       tot_wdata;
	logic [FID_W-1:0]                 tot_raddr;
	logic [cset_pkg::TOT_W-1:0]       tot_rdata;
	logic [cset_pkg::TOT_W-1:0]       new_tot;

	logic                             stk_we;
	logic [SP_W-1:0]                  stk_waddr;
	logic [SENT_W-1:0]                stk_wdata;
	logic [SP_W-1:0]                  stk_raddr;
	logic [SENT_W-1:0]                stk_rdata;
	logic [LVL_W-1:0]                 lvl_m1;
	logic [LVL_W-1:0]                 lvl_m2;
	logic                             credit;

	assign accept   = start && (state_q == S_IDLE);
	assign busy     = (state_q != S_IDLE);
	assign fid_fold = fold_id(func_id);
	assign lvl_m1   = level_q - LVL_W'(1);
	assign lvl_m2   = level_q - LVL_W'(2);

	// An end event counts its own tick, hence the extra one.
	assign now_d     = {1'b0, timestamp} + cset_pkg::TOT_W'(mode == cset_pkg::MODE_END);
	assign elapsed_d = now_d - {1'b0, top_time_q};

	always_comb begin
		op_d   = OP_NONE;
		stat_d = cset_pkg::ST_OK;
		case (mode)
			cset_pkg::MODE_START: begin
				if (level_q == LVL_W'(STACK_DEPTH)) begin
					stat_d = cset_pkg::ST_OVERFLOW;
				end else if (level_q == '0) begin
					op_d = OP_PUSH_FIRST;
				end else begin
					op_d = OP_PUSH;
				end
			end
			cset_pkg::MODE_END: begin
				if (level_q == '0) begin
					stat_d = cset_pkg::ST_UNDERFLOW;
				end else begin
					op_d = OP_POP;
				end
			end
			cset_pkg::MODE_READ: begin
				op_d = OP_READ;
			end
			default: begin
				op_d = OP_NONE;
			end
		endcase
	end

	assign credit  = (state_q == S_EXEC) && ((op_s1 == OP_PUSH) || (op_s1 == OP_POP));
	assign new_tot = tot_rdata + elapsed_s1;

	// Totals memory: swept to zero after reset, then read at accept and
	// written back in the execute cycle of an event that credits time.
	assign tot_raddr = (mode == cset_pkg::MODE_READ) ? fid_fold : top_id_q;
	assign tot_we    = (state_q == S_CLEAR) || credit;
	assign tot_waddr = (state_q == S_CLEAR) ? clr_q : top_id_q;
	assign tot_wdata = (state_q == S_CLEAR) ? '0 : new_tot;

	cset_ram #(
		.W     (cset_pkg::TOT_W),
		.DEPTH (MAX_FUNCS),
		.AW    (FID_W)
	) u_totals (
		.clk   (clk),
		.we    (tot_we),
		.waddr (tot_waddr),
		.wdata (tot_wdata),
		.re    (accept),
		.raddr (tot_raddr),
		.rdata (tot_rdata)
	);

	// Stack memory holds the id of every entry below the running function.
	// A caller always resumes on the tick after its callee ends, so its
	// earlier resume time is never needed again.
	assign stk_we    = (state_q == S_EXEC) && (op_s1 == OP_PUSH);
	assign stk_waddr = lvl_m1[SP_W-1:0];
	assign stk_wdata = top_id_q;
	assign stk_raddr = lvl_m2[SP_W-1:0];

	cset_ram #(
		.W     (SENT_W),
		.DEPTH (STACK_DEPTH - 1),
		.AW    (SP_W)
	) u_stack (
		.clk   (clk),
		.we    (stk_we),
		.waddr (stk_waddr),
		.wdata (stk_wdata),
		.re    (accept),
		.raddr (stk_raddr),
		.rdata (stk_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_q   <= '0;
			level_q <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + FID_W'(1);
					if (clr_q == FID_W'(MAX_FUNCS - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (start) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					state_q <= S_IDLE;
					done_q  <= 1'b1;
					if ((op_s1 == OP_PUSH) || (op_s1 == OP_PUSH_FIRST)) begin
						level_q <= level_q + LVL_W'(1);
					end else if (op_s1 == OP_POP) begin
						level_q <= lvl_m1;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1      <= op_d;
			stat_s1    <= stat_d;
			fid_s1     <= fid_fold;
			ts_s1      <= timestamp;
			elapsed_s1 <= elapsed_d;
		end
		if (state_q == S_EXEC) begin
			if ((op_s1 == OP_PUSH) || (op_s1 == OP_PUSH_FIRST)) begin
				top_id_q   <= fid_s1;
				top_time_q <= ts_s1;
			end else if ((op_s1 == OP_POP) && (level_q > LVL_W'(1))) begin
				// The caller resumes on the tick after the end event.
				top_id_q   <= stk_rdata;
				top_time_q <= ts_s1 + cset_pkg::TS_W'(1);
			end
			status_q <= stat_s1;
			case (op_s1)
				OP_PUSH, OP_POP: begin
					valid_q <= 1'b1;
					id_q    <= cset_pkg::ID_W'(top_id_q);
					total_q <= new_tot;
				end
				OP_READ: begin
					valid_q <= 1'b1;
					id_q    <= cset_pkg::ID_W'(fid_s1);
					total_q <= tot_rdata;
				end
				default: begin
					valid_q <= 1'b0;
					id_q    <= '0;
					total_q <= '0;
				end
			endcase
		end
	end

	assign done           = done_q;
	assign status         = status_q;
	assign credited_valid = valid_q;
	assign credited_id    = id_q;
	assign credited_total = total_q;

endmodule

// ----- rtl/core/cset_checker.sv -----
// ----------------------------------------------------------------------------
// cset_checker
// Port-level checks on the call stack exclusive timer, bound to its top level.
// ----------------------------------------------------------------------------
module cset_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          start,
	input logic                          busy,
	input logic                          done,
	input logic [cset_pkg::STATUS_W-1:0] status,
	input logic                          credited_valid,
	input logic [cset_pkg::ID_W-1:0]     credited_id,
	input logic [cset_pkg::TOT_W-1:0]    credited_total
);

	// A transfer in always yields its result once its execute cycle has passed.
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> ##1 done)
		else $error("result missing two cycles after an accepted event");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("busy not raised after an accepted event");

	a_idle_with_result: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result shown while busy");

	a_error_no_credit: assert property (@(posedge clk) disable iff (!arst_n)
		done && (status != cset_pkg::ST_OK) |-> !credited_valid)
		else $error("ignored event reports a total");

	a_quiet_payload: assert property (@(posedge clk) disable iff (!arst_n)
		done && !credited_valid |-> (credited_id == '0) && (credited_total == '0))
		else $error("id or total nonzero without a credit");

endmodule

bind call_stack_exclusive_timer cset_checker u_cset_checker (.*);

// ----- tb/sv/call_stack_exclusive_timer_tb.sv -----
// ----------------------------------------------------------------------------
// call_stack_exclusive_timer_tb
// Drives call, return, read and unused-mode events into the exclusive-time
// profiler and checks every result against a cycle-free predictor of the call
// stack and of the per-function totals kept in the testbench.
// ----------------------------------------------------------------------------
module call_stack_exclusive_timer_tb;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int NUM_FUNCS   = 256;
	localparam int STACK_SLOTS = 256;
	localparam int CYCLE_LIMIT = 200000;
	localparam int DRAIN_CYCLES = 8;
	localparam int TRACE_EVENTS = 310;
	localparam logic [cset_pkg::MODE_W-1:0] MODE_UNUSED = 2'd3;

	typedef struct packed {
		logic [cset_pkg::STATUS_W-1:0] status;
		logic                          valid;
		logic [cset_pkg::ID_W-1:0]     id;
		logic [cset_pkg::TOT_W-1:0]    total;
	} credit_rec_t;

	logic                          clk = 1'b0;
	logic                          arst_n = 1'b0;
	logic                          start = 1'b0;
	logic [cset_pkg::MODE_W-1:0]   mode = '0;
	logic [cset_pkg::ID_W-1:0]     func_id = '0;
	logic [cset_pkg::TS_W-1:0]     timestamp = '0;
	logic                          busy;
	logic                          done;
	logic [cset_pkg::STATUS_W-1:0] status;
	logic                          credited_valid;
	logic [cset_pkg::ID_W-1:0]     credited_id;
	logic [cset_pkg::TOT_W-1:0]    credited_total;

	// Predicted profiler state.
	logic [cset_pkg::TOT_W-1:0] func_time [NUM_FUNCS];
	logic [cset_pkg::ID_W-1:0]  frame_id [STACK_SLOTS];
	logic [cset_pkg::TS_W-1:0]  frame_resume [STACK_SLOTS];
	int                         frame_count = 0;

	credit_rec_t pending_credits [$];
	int          mismatch_count = 0;
	int          events_sent = 0;
	int          results_checked = 0;
	int          overflow_seen = 0;
	int          underflow_seen = 0;
	int          deepest_stack = 0;
	int          cycle_count = 0;
	int          burst_left = 0;
	logic [cset_pkg::TS_W-1:0] clock_now;

	call_stack_exclusive_timer dut (.*);

	always #10 clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("%0t: run timed out after %0d cycles", $time, cycle_count);
			$display("tb: failure");
			$finish;
		end
	end

	function automatic logic [cset_pkg::TOT_W-1:0] add_time(
		input logic [cset_pkg::ID_W-1:0] fid,
		input logic [cset_pkg::TOT_W-1:0] now, input logic [cset_pkg::TS_W-1:0] since);
		func_time[fid] = func_time[fid] + (now - {1'b0, since});
		return func_time[fid];
	endfunction

	function automatic credit_rec_t profile_event(input logic [cset_pkg::MODE_W-1:0] m,
		input logic [cset_pkg::ID_W-1:0] fid, input logic [cset_pkg::TS_W-1:0] ts);
		credit_rec_t                r;
		logic [cset_pkg::TOT_W-1:0] now;
		r = '0;
		case (m)
			cset_pkg::MODE_START: begin
				if (frame_count >= STACK_SLOTS) begin
					r.status = cset_pkg::ST_OVERFLOW;
				end else begin
					if (frame_count > 0) begin
						r.valid = 1'b1;
						r.id    = frame_id[frame_count-1];
						r.total = add_time(r.id, {1'b0, ts}, frame_resume[frame_count-1]);
					end
					frame_id[frame_count]     = fid;
					frame_resume[frame_count] = ts;
					frame_count++;
				end
			end
			cset_pkg::MODE_END: begin
				if (frame_count == 0) begin
					r.status = cset_pkg::ST_UNDERFLOW;
				end else begin
					// The returning function is charged through the end tick itself.
					now     = {1'b0, ts} + 33'd1;
					r.valid = 1'b1;
					r.id    = frame_id[frame_count-1];
					r.total = add_time(r.id, now, frame_resume[frame_count-1]);
					frame_count--;
					if (frame_count > 0)
						frame_resume[frame_count-1] = now[cset_pkg::TS_W-1:0];
				end
			end
			cset_pkg::MODE_READ: begin
				r.valid = 1'b1;
				r.id    = fid;
				r.total = func_time[fid];
			end
			default: begin
			end
		endcase
		return r;
	endfunction

	// Called at a falling edge; returns at the falling edge after the transfer
	// with start still high, so a back-to-back event needs no extra edge on it.
	task automatic send_event(input logic [cset_pkg::MODE_W-1:0] m,
		input logic [cset_pkg::ID_W-1:0] fid, input logic [cset_pkg::TS_W-1:0] ts);
		bit          taken;
		credit_rec_t rec;
		start     <= 1'b1;
		mode      <= m;
		func_id   <= fid;
		timestamp <= ts;
		do begin
			@(posedge clk);
			taken = !busy;
		end while (!taken);
		rec = profile_event(m, fid, ts);
		pending_credits = {pending_credits, rec};
		events_sent++;
		if (frame_count > deepest_stack)
			deepest_stack = frame_count;
		@(negedge clk);
	endtask

	task automatic pace();
		int gap;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			gap = $urandom_range(1, 12);
			start <= 1'b0;
			repeat (gap) @(negedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 80)
			                                         : $urandom_range(0, 10);
		end
	endtask

	task automatic sequence_event(input logic [cset_pkg::MODE_W-1:0] m,
		input logic [cset_pkg::ID_W-1:0] fid, input logic [cset_pkg::TS_W-1:0] ts);
		send_event(m, fid, ts);
		pace();
	endtask

	task automatic check_field(input string name, input logic [cset_pkg::TOT_W-1:0] want,
		input logic [cset_pkg::TOT_W-1:0] got);
		if (got !== want) begin
			$display("%0t: %s expected 0x%0h, got 0x%0h", $time, name, want, got);
			mismatch_count++;
		end
	endtask

	always @(posedge clk) begin
		credit_rec_t want;
		if (arst_n && done) begin
			if (pending_credits.size() == 0) begin
				$display("%0t: result with nothing expected, status %0d id 0x%0h total 0x%0h",
					$time, status, credited_id, credited_total);
				mismatch_count++;
			end else begin
				want = pending_credits.pop_front();
				check_field("status", want.status, status);
				check_field("credited_valid", want.valid, credited_valid);
				check_field("credited_id", want.id, credited_id);
				check_field("credited_total", want.total, credited_total);
				results_checked++;
				if (status == cset_pkg::ST_OVERFLOW)
					overflow_seen++;
				if (status == cset_pkg::ST_UNDERFLOW)
					underflow_seen++;
			end
		end
	end

	// Totals start cleared; return on an empty stack and the unused mode do nothing.
	task automatic test_idle_reads();
		sequence_event(cset_pkg::MODE_READ, 8'h00, 32'h0000_0000);
		sequence_event(cset_pkg::MODE_READ, 8'hFF, 32'hFFFF_FFFF);
		sequence_event(cset_pkg::MODE_END, 8'hA5, 32'h0000_0010);
		sequence_event(MODE_UNUSED, 8'h5A, 32'h0000_0020);
		sequence_event(cset_pkg::MODE_READ, 8'h5A, 32'h0000_0030);
	endtask

	task automatic test_nested_calls();
		sequence_event(cset_pkg::MODE_START, 8'h01, 32'd100);
		sequence_event(cset_pkg::MODE_START, 8'h80, 32'd110);
		sequence_event(cset_pkg::MODE_START, 8'h01, 32'd112);
		sequence_event(cset_pkg::MODE_END, 8'hFF, 32'd115);
		sequence_event(cset_pkg::MODE_END, 8'h00, 32'd118);
		sequence_event(cset_pkg::MODE_END, 8'h00, 32'd125);
		sequence_event(cset_pkg::MODE_READ, 8'h01, 32'd126);
		sequence_event(cset_pkg::MODE_READ, 8'h80, 32'd126);
		sequence_event(cset_pkg::MODE_END, 8'h01, 32'd130);
	endtask

	// Resume time wraps past all ones, and backward time makes the totals wrap.
	task automatic test_time_wrap();
		sequence_event(cset_pkg::MODE_START, 8'hFF, 32'hFFFF_FFF0);
		sequence_event(cset_pkg::MODE_START, 8'h7F, 32'hFFFF_FFFF);
		sequence_event(cset_pkg::MODE_END, 8'h00, 32'hFFFF_FFFF);
		sequence_event(cset_pkg::MODE_END, 8'h00, 32'h0000_0005);
		sequence_event(cset_pkg::MODE_START, 8'h55, 32'h8000_0000);
		sequence_event(cset_pkg::MODE_START, 8'hAA, 32'h0000_0003);
		sequence_event(cset_pkg::MODE_START, 8'h55, 32'hFFFF_FFFE);
		sequence_event(cset_pkg::MODE_END, 8'h00, 32'h0000_0001);
		sequence_event(cset_pkg::MODE_END, 8'h00, 32'h0000_0000);
		sequence_event(cset_pkg::MODE_END, 8'h00, 32'h7000_0000);
		sequence_event(cset_pkg::MODE_READ, 8'h55, 32'h7000_0000);
		sequence_event(cset_pkg::MODE_READ, 8'hAA, 32'h7000_0000);
	endtask

	task automatic test_stack_limits();
		logic [cset_pkg::TS_W-1:0] ts;
		ts = 32'h0100_0000;
		for (int i = 0; i < STACK_SLOTS; i++) begin
			ts = ts + $urandom_range(0, 3);
			sequence_event(cset_pkg::MODE_START, 8'(i), ts);
		end
		sequence_event(cset_pkg::MODE_START, 8'h3C, ts + 1);
		sequence_event(cset_pkg::MODE_READ, 8'hFE, ts + 1);
		for (int i = 0; i < STACK_SLOTS; i++) begin
			ts = ts + $urandom_range(1, 3);
			sequence_event(cset_pkg::MODE_END, 8'($urandom), ts);
		end
		sequence_event(cset_pkg::MODE_END, 8'h00, ts + 2);
	endtask

	// Mostly well-formed call traces over a small set of ids, with some noise.
	task automatic test_random_trace();
		logic [cset_pkg::MODE_W-1:0] m;
		logic [cset_pkg::ID_W-1:0]   fid;
		logic [cset_pkg::TS_W-1:0]   ts;
		int                          pick;
		clock_now = $urandom;
		for (int n = 0; n < TRACE_EVENTS; n++) begin
			pick = $urandom_range(0, 99);
			fid  = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 7));
			ts   = clock_now + $urandom_range(0, 40);
			if ($urandom_range(0, 49) == 0)
				ts = ts + $urandom_range(0, 32'h00FF_FFFF);
			if (pick < 6) begin
				case ($urandom_range(0, 2))
					0: m = MODE_UNUSED;
					1: m = $urandom_range(0, 1) ? cset_pkg::MODE_START : cset_pkg::MODE_END;
					default: m = cset_pkg::MODE_END;
				endcase
				if (m != MODE_UNUSED && $urandom_range(0, 1))
					ts = $urandom;
			end else if (pick < 18) begin
				m = cset_pkg::MODE_READ;
			end else if (frame_count == 0 || (frame_count < 24 && $urandom_range(0, 1))) begin
				m = cset_pkg::MODE_START;
			end else begin
				m = cset_pkg::MODE_END;
			end
			sequence_event(m, fid, ts);
			clock_now = (m == cset_pkg::MODE_END) ? ts + 1 : ts;
		end
	endtask

	initial begin
		for (int i = 0; i < NUM_FUNCS; i++)
			func_time[i] = '0;
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_idle_reads();
		test_nested_calls();
		test_time_wrap();
		test_stack_limits();
		test_random_trace();
		start <= 1'b0;
		while (pending_credits.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("Sent %0d events and checked %0d results; deepest stack %0d.",
			events_sent, results_checked, deepest_stack);
		$display("Overflow results %0d, underflow results %0d, mismatches %0d.",
			overflow_seen, underflow_seen, mismatch_count);
		if (mismatch_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

// ----- sim.f -----
rtl/core/cset_pkg.sv
rtl/core/cset_ram.sv
rtl/core/call_stack_exclusive_timer.sv
rtl/core/cset_checker.sv
tb/sv/call_stack_exclusive_timer_tb.sv
